[hw/rtl/ngad_pkg.sv]
// Shared constants, register indexes and types of the noise gate activity detector.
`default_nettype none

package ngad_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int HOLD_BITS      = 21;
   localparam int THR_BITS       = 24;
   localparam int HOLD_CFG_BITS  = 21;
   localparam int TIME_BITS      = 32;
   localparam int ENABLE_BITS    = 2;
   localparam int GAIN_BITS      = 24;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam int LEVEL_BITS =
      ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 2;
   localparam int COUNT_CMP_BITS =
      (HOLD_BITS > HOLD_CFG_BITS) ? HOLD_BITS : HOLD_CFG_BITS;

   localparam logic [GAIN_BITS-1:0] GAIN_ONE = 24'd8388608;
   localparam int LEVEL_MIN_VALUE = -16777216;
   localparam logic signed [LEVEL_BITS-1:0] LEVEL_MIN = LEVEL_BITS'(LEVEL_MIN_VALUE);

   localparam int SOUND_ENABLE_BIT  = 0;
   localparam int VISUAL_ENABLE_BIT = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_OPEN_LIMIT         = 3'd0,
      CSR_CLOSE_LIMIT        = 3'd1,
      CSR_ATTACK_STEP        = 3'd2,
      CSR_RELEASE_STEP       = 3'd3,
      CSR_DECAY_STEP         = 3'd4,
      CSR_HOLD_FRAMES        = 3'd5,
      CSR_REPEAT_INTERVAL_MS = 3'd6,
      CSR_INDICATOR_ENABLES  = 3'd7
   } csr_index_type;

   localparam logic [THR_BITS-1:0]      OPEN_LIMIT_RESET         = 24'd420430;
   localparam logic [THR_BITS-1:0]      CLOSE_LIMIT_RESET        = 24'd210728;
   localparam logic [THR_BITS-1:0]      ATTACK_STEP_RESET        = 24'd6990;
   localparam logic [THR_BITS-1:0]      RELEASE_STEP_RESET       = 24'd1165;
   localparam logic [THR_BITS-1:0]      DECAY_STEP_RESET         = 24'd328;
   localparam logic [HOLD_CFG_BITS-1:0] HOLD_FRAMES_RESET        = 21'd9600;
   localparam logic [TIME_BITS-1:0]     REPEAT_INTERVAL_MS_RESET = 32'd1500;
   localparam logic [ENABLE_BITS-1:0]   INDICATOR_ENABLES_RESET  = 2'd2;

   typedef struct packed {
      logic [THR_BITS-1:0]      open_limit;
      logic [THR_BITS-1:0]      close_limit;
      logic [THR_BITS-1:0]      attack_step;
      logic [THR_BITS-1:0]      release_step;
      logic [THR_BITS-1:0]      decay_step;
      logic [HOLD_CFG_BITS-1:0] hold_frames;
      logic [TIME_BITS-1:0]     repeat_interval_ms;
      logic [ENABLE_BITS-1:0]   indicator_enables;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last_channel;
      logic                          last_in_buffer;
      logic [TIME_BITS-1:0]          now_ms;
      logic                          source_muted;
   } req_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } stage_type;

endpackage

`default_nettype wire

[hw/rtl/ngad_req_if.sv]
// Channel interface that carries input samples into the detector.
`default_nettype none

interface ngad_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ngad_pkg::SAMPLE_BITS-1:0] sample;
   logic                                   last_channel;
   logic                                   last_in_buffer;
   logic [ngad_pkg::TIME_BITS-1:0]          now_ms;
   logic                                   source_muted;

   modport source (
      output valid, sample, last_channel, last_in_buffer, now_ms, source_muted,
      input  ready
   );

   modport sink (
      input  valid, sample, last_channel, last_in_buffer, now_ms, source_muted,
      output ready
   );
endinterface

`default_nettype wire

[hw/rtl/ngad_rsp_if.sv]
// Channel interface that carries gate results out of the detector.
`default_nettype none

interface ngad_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           gate_open;
   logic [ngad_pkg::GAIN_BITS-1:0] gain;
   logic                           play_sound;
   logic                           show_visual;

   modport source (
      output valid, gate_open, gain, play_sound, show_visual,
      input  ready
   );

   modport sink (
      input  valid, gate_open, gain, play_sound, show_visual,
      output ready
   );
endinterface

`default_nettype wire

[hw/rtl/noise_gate_activity_detector.sv]
// Top level of the noise gate activity detector.
//
// Samples enter one channel at a time on req_if, a valid/ready channel that
// carries the sample, the frame and buffer end marks, the time in ms and the
// source mute flag. Every accepted transfer produces exactly one transfer on
// rsp_if with the gate state, the gain envelope and the notify pulses.
// The csr_ port writes one configuration register per cycle at the given index.
// A sample passes an input register and then the gate logic, which updates the
// state and loads the result register, from which rsp_if offers the result.
// One sample is accepted every cycle while the receiver takes results, and the
// state held from one sample to the next is updated in the gate logic as the result is loaded.
// When the receiver stalls, the result register holds its transfer and an empty
// input register still takes one more sample; after that req_if.ready drops
// until the result is taken. A synchronous reset empties both registers,
// closes the gate, clears level, envelope, hold count and notify time, and
// loads the default configuration.
`default_nettype none

module noise_gate_activity_detector (
   input  wire logic                                clock,
   input  wire logic                                reset,
   ngad_req_if.sink                                 req_if,
   ngad_rsp_if.source                               rsp_if,
   input  wire logic                                csr_write_enable,
   input  wire logic [ngad_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ngad_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   ngad_pkg::cfg_type   cfg;
   ngad_pkg::stage_type stage;
   logic                advance;

   ngad_cfg_regs u_cfg_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   ngad_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .advance (advance),
      .stage   (stage)
   );

   ngad_gate_core u_gate_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .stage   (stage),
      .advance (advance),
      .rsp_if  (rsp_if)
   );

   // A sound pulse is only raised while the gate is open.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.play_sound) |-> rsp_if.gate_open)
      else $error("sound pulse with closed gate");

   // The gain never exceeds full scale.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.gain <= ngad_pkg::GAIN_ONE))
      else $error("gain above full scale");

   // With the result register empty the input side must take samples.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_if.valid |-> req_if.ready)
      else $error("input stalled while result register empty");

endmodule

`default_nettype wire

[hw/rtl/ngad_cfg_regs.sv]
// Configuration register file of the detector with its write port.
`default_nettype none

module ngad_cfg_regs (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [ngad_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [ngad_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output ngad_pkg::cfg_type                        cfg
);

   ngad_pkg::cfg_type cfg_ff;
   ngad_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (ngad_pkg::csr_index_type'(csr_index))
            ngad_pkg::CSR_OPEN_LIMIT: begin
               cfg_in.open_limit = csr_write_data[ngad_pkg::THR_BITS-1:0];
            end
            ngad_pkg::CSR_CLOSE_LIMIT: begin
               cfg_in.close_limit = csr_write_data[ngad_pkg::THR_BITS-1:0];
            end
            ngad_pkg::CSR_ATTACK_STEP: begin
               cfg_in.attack_step = csr_write_data[ngad_pkg::THR_BITS-1:0];
            end
            ngad_pkg::CSR_RELEASE_STEP: begin
               cfg_in.release_step = csr_write_data[ngad_pkg::THR_BITS-1:0];
            end
            ngad_pkg::CSR_DECAY_STEP: begin
               cfg_in.decay_step = csr_write_data[ngad_pkg::THR_BITS-1:0];
            end
            ngad_pkg::CSR_HOLD_FRAMES: begin
               cfg_in.hold_frames = csr_write_data[ngad_pkg::HOLD_CFG_BITS-1:0];
            end
            ngad_pkg::CSR_REPEAT_INTERVAL_MS: begin
               cfg_in.repeat_interval_ms = csr_write_data[ngad_pkg::TIME_BITS-1:0];
            end
            ngad_pkg::CSR_INDICATOR_ENABLES: begin
               cfg_in.indicator_enables = csr_write_data[ngad_pkg::ENABLE_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_limit         <= ngad_pkg::OPEN_LIMIT_RESET;
         cfg_ff.close_limit        <= ngad_pkg::CLOSE_LIMIT_RESET;
         cfg_ff.attack_step        <= ngad_pkg::ATTACK_STEP_RESET;
         cfg_ff.release_step       <= ngad_pkg::RELEASE_STEP_RESET;
         cfg_ff.decay_step         <= ngad_pkg::DECAY_STEP_RESET;
         cfg_ff.hold_frames        <= ngad_pkg::HOLD_FRAMES_RESET;
         cfg_ff.repeat_interval_ms <= ngad_pkg::REPEAT_INTERVAL_MS_RESET;
         cfg_ff.indicator_enables  <= ngad_pkg::INDICATOR_ENABLES_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hw/rtl/ngad_in_stage.sv]
// Input register stage that captures one sample transfer per cycle while it is empty or the gate core advances.
`default_nettype none

module ngad_in_stage (
   input  wire logic      clock,
   input  wire logic      reset,
   ngad_req_if.sink       req_if,
   input  wire logic      advance,
   output ngad_pkg::stage_type stage
);

   logic              valid_ff;
   logic              valid_in;
   ngad_pkg::req_type item_ff;
   logic              accept;

   assign req_if.ready = !valid_ff || advance;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.sample         <= req_if.sample;
         item_ff.last_channel   <= req_if.last_channel;
         item_ff.last_in_buffer <= req_if.last_in_buffer;
         item_ff.now_ms         <= req_if.now_ms;
         item_ff.source_muted   <= req_if.source_muted;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

`default_nettype wire

[hw/rtl/ngad_gate_core.sv]
// Gate state, envelope and notification logic with the result register.
`default_nettype none

module ngad_gate_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  ngad_pkg::cfg_type  cfg,
   input  ngad_pkg::stage_type stage,
   output logic               advance,
   ngad_rsp_if.source         rsp_if
);

   localparam int SB = ngad_pkg::SAMPLE_BITS;
   localparam int LB = ngad_pkg::LEVEL_BITS;
   localparam int GB = ngad_pkg::GAIN_BITS;
   localparam int HB = ngad_pkg::HOLD_BITS;
   localparam int CB = ngad_pkg::COUNT_CMP_BITS;
   localparam int TB = ngad_pkg::TIME_BITS;

   // Item state.
   logic [SB-1:0]        peak_ff,   peak_in;
   logic                 gate_ff,   gate_in;
   logic signed [LB-1:0] level_ff,  level_in;
   logic [GB-1:0]        env_ff,    env_in;
   logic [HB-1:0]        count_ff,  count_in;
   logic [TB-1:0]        notify_ff, notify_in;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_gate_ff,  rsp_gate_in;
   logic [GB-1:0] rsp_gain_ff,  rsp_gain_in;
   logic          rsp_sound_ff, rsp_sound_in;
   logic          rsp_visual_ff, rsp_visual_in;

   logic                 fire;
   logic [SB-1:0]        sample_bits;
   logic [SB-1:0]        magnitude;
   logic [SB-1:0]        peak_cur;
   logic                 open_hit;
   logic                 gate_opened;
   logic                 level_below;
   logic                 gate_run;
   logic [HB-1:0]        count_cleared;
   logic [HB-1:0]        count_inc;
   logic signed [LB-1:0] peak_signed;
   logic signed [LB-1:0] level_max;
   logic signed [LB-1:0] level_sub;
   logic signed [LB-1:0] level_sat;
   logic [GB:0]          env_sum;
   logic [GB-1:0]        env_attack;
   logic [GB-1:0]        env_release;
   logic                 release_go;
   logic                 gate_after;
   logic [TB-1:0]        elapsed;
   logic                 notify_fire;

   assign advance = !rsp_valid_ff || rsp_if.ready;
   assign fire    = stage.valid && advance;

   always_comb begin
      sample_bits = stage.item.sample;
      magnitude   = sample_bits[SB-1] ? (~sample_bits + SB'(1)) : sample_bits;
      peak_cur    = (magnitude > peak_ff) ? magnitude : peak_ff;

      open_hit    = LB'(peak_cur) > LB'(cfg.open_limit);
      gate_opened = gate_ff || open_hit;
      level_below = level_ff < $signed(LB'(cfg.close_limit));
      gate_run    = gate_opened && !level_below;
      count_cleared = (gate_opened && level_below) ? '0 : count_ff;

      peak_signed = $signed(LB'(peak_cur));
      level_max   = (peak_signed > level_ff) ? peak_signed : level_ff;
      level_sub   = level_max - $signed(LB'(cfg.decay_step));
      level_sat   = (level_sub < ngad_pkg::LEVEL_MIN) ? ngad_pkg::LEVEL_MIN : level_sub;

      env_sum    = {1'b0, env_ff} + (GB + 1)'(cfg.attack_step);
      env_attack = (env_sum > (GB + 1)'(ngad_pkg::GAIN_ONE)) ?
                   ngad_pkg::GAIN_ONE : env_sum[GB-1:0];
      env_release = (env_ff > GB'(cfg.release_step)) ?
                    (env_ff - GB'(cfg.release_step)) : '0;
      count_inc  = (count_cleared == {HB{1'b1}}) ? count_cleared :
                   (count_cleared + HB'(1));
      release_go = CB'(count_inc) > CB'(cfg.hold_frames);

      gate_after  = stage.item.last_channel ? gate_run : gate_ff;
      elapsed     = stage.item.now_ms - notify_ff;
      notify_fire = stage.item.last_in_buffer && gate_after &&
                    (elapsed > cfg.repeat_interval_ms);
   end

   always_comb begin
      peak_in   = peak_ff;
      gate_in   = gate_ff;
      level_in  = level_ff;
      env_in    = env_ff;
      count_in  = count_ff;
      notify_in = notify_ff;
      rsp_sound_in  = 1'b0;
      rsp_visual_in = 1'b0;
      if (!stage.item.source_muted) begin
         gate_in = 1'b0;
         if (stage.item.last_channel) begin
            peak_in = '0;
         end
      end else begin
         if (stage.item.last_channel) begin
            peak_in  = '0;
            gate_in  = gate_run;
            level_in = level_sat;
            if (gate_run) begin
               env_in = env_attack;
            end else begin
               count_in = count_inc;
               if (release_go) begin
                  env_in = env_release;
               end
            end
         end else begin
            peak_in = peak_cur;
         end
         if (notify_fire) begin
            notify_in     = stage.item.now_ms;
            rsp_sound_in  = cfg.indicator_enables[ngad_pkg::SOUND_ENABLE_BIT];
            rsp_visual_in = cfg.indicator_enables[ngad_pkg::VISUAL_ENABLE_BIT];
         end
      end
      rsp_gate_in = gate_in;
      rsp_gain_in = env_in;
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = stage.valid;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         gate_ff      <= 1'b0;
         level_ff     <= '0;
         env_ff       <= '0;
         count_ff     <= '0;
         notify_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            peak_ff   <= peak_in;
            gate_ff   <= gate_in;
            level_ff  <= level_in;
            env_ff    <= env_in;
            count_ff  <= count_in;
            notify_ff <= notify_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_gate_ff   <= rsp_gate_in;
         rsp_gain_ff   <= rsp_gain_in;
         rsp_sound_ff  <= rsp_sound_in;
         rsp_visual_ff <= rsp_visual_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.gate_open   = rsp_gate_ff;
   assign rsp_if.gain        = rsp_gain_ff;
   assign rsp_if.play_sound  = rsp_sound_ff;
   assign rsp_if.show_visual = rsp_visual_ff;

endmodule

`default_nettype wire
